>>> design/ip4_pkg.sv
// Shared types and codes of the 4x4 intra predictor.
// No dependencies; ip4_nbr_prep, ip4_lane and the top level import this package.
package ip4_pkg;

  typedef logic [7:0] pel_t;
  typedef pel_t [3:0] pel_row_t;
  // Neighbor line, left-bottom to above-right:
  // [0],[1] left_3, [2] left_2, [3] left_1, [4] left_0, [5] corner,
  // [6..9] above_0..above_3, [10..15] above_3 replicated.
  typedef pel_t [15:0] nbr_line_t;

  localparam logic [3:0] MODE_VERT = 4'd0;
  localparam logic [3:0] MODE_HORZ = 4'd1;
  localparam logic [3:0] MODE_DC   = 4'd2;
  localparam logic [3:0] MODE_DDL  = 4'd3;
  localparam logic [3:0] MODE_DDR  = 4'd4;
  localparam logic [3:0] MODE_VR   = 4'd5;
  localparam logic [3:0] MODE_HD   = 4'd6;
  localparam logic [3:0] MODE_VL   = 4'd7;
  localparam logic [3:0] MODE_HU   = 4'd8;

  localparam pel_t       FILL_PEL  = 8'd128;
  localparam logic [1:0] LAST_ROW  = 2'd3;

  typedef enum logic [2:0] {
    KIND_COPY,
    KIND_AVG2,
    KIND_AVG3,
    KIND_DC,
    KIND_FILL
  } pel_kind_e;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] row;
    logic [1:0] col;
  } lane_ctrl_t;

endpackage

>>> design/ip4_chan_if.sv
// Channel interfaces of the 4x4 intra predictor: neighbor block in, row out.
// Valid/ready handshake; no dependencies.
interface ip4_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] above_0;
  logic [7:0] above_1;
  logic [7:0] above_2;
  logic [7:0] above_3;
  logic [7:0] left_0;
  logic [7:0] left_1;
  logic [7:0] left_2;
  logic [7:0] left_3;
  logic [7:0] corner;

  modport source (output valid, mode, above_0, above_1, above_2, above_3,
                  left_0, left_1, left_2, left_3, corner, input ready);
  modport sink   (input valid, mode, above_0, above_1, above_2, above_3,
                  left_0, left_1, left_2, left_3, corner, output ready);
endinterface

interface ip4_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] row_index;
  logic [7:0] pel_0;
  logic [7:0] pel_1;
  logic [7:0] pel_2;
  logic [7:0] pel_3;
  logic       last_row;

  modport source (output valid, row_index, pel_0, pel_1, pel_2, pel_3, last_row,
                  input ready);
  modport sink   (input valid, row_index, pel_0, pel_1, pel_2, pel_3, last_row,
                  output ready);
endinterface

>>> design/ip4_nbr_prep.sv
// Builds the neighbor line and the DC value shared by all lanes.
// Depends on ip4_pkg.
module ip4_nbr_prep (
  input  ip4_pkg::pel_row_t  above_i,
  input  ip4_pkg::pel_row_t  left_i,
  input  ip4_pkg::pel_t      corner_i,
  output ip4_pkg::nbr_line_t nbr_o,
  output ip4_pkg::pel_t      dc_o
);
  import ip4_pkg::*;

  logic [10:0] dc_sum;

  always_comb begin
    nbr_o[0] = left_i[3];
    nbr_o[1] = left_i[3];
    nbr_o[2] = left_i[2];
    nbr_o[3] = left_i[1];
    nbr_o[4] = left_i[0];
    nbr_o[5] = corner_i;
    for (int i = 0; i < 4; i++) begin
      nbr_o[6 + i] = above_i[i];
    end
    // no above-right samples: repeat above_3
    for (int i = 10; i < 16; i++) begin
      nbr_o[i] = above_i[3];
    end
  end

  assign dc_sum = 11'(above_i[0]) + 11'(above_i[1]) + 11'(above_i[2]) + 11'(above_i[3])
                + 11'(left_i[0])  + 11'(left_i[1])  + 11'(left_i[2])  + 11'(left_i[3])
                + 11'd4;
  assign dc_o   = dc_sum[10:3];

endmodule

>>> design/ip4_lane.sv
// One pixel lane: picks the filter tap window for its column and the current
// row, then applies copy, 2-tap or 3-tap average, DC or fill. Depends on ip4_pkg.
module ip4_lane (
  input  ip4_pkg::lane_ctrl_t ctrl_i,
  input  ip4_pkg::nbr_line_t  nbr_i,
  input  ip4_pkg::pel_t       dc_i,
  output ip4_pkg::pel_t       pel_o
);
  import ip4_pkg::*;

  pel_kind_e   kind;
  logic [3:0]  base;
  pel_t        tap_a;
  pel_t        tap_b;
  pel_t        tap_c;
  logic [9:0]  sum2;
  logic [9:0]  sum3;

  always_comb begin
    logic signed [4:0] xs;
    logic signed [4:0] ys;
    logic signed [4:0] zv;
    logic signed [4:0] kv;
    xs   = signed'({3'b000, ctrl_i.col});
    ys   = signed'({3'b000, ctrl_i.row});
    zv   = '0;
    kv   = '0;
    kind = KIND_FILL;
    base = '0;
    case (ctrl_i.mode)
      MODE_VERT: begin
        kind = KIND_COPY;
        base = 4'(xs + 5'sd6);
      end
      MODE_HORZ: begin
        kind = KIND_COPY;
        base = 4'(5'sd4 - ys);
      end
      MODE_DC: begin
        kind = KIND_DC;
      end
      MODE_DDL: begin
        kind = KIND_AVG3;
        base = 4'(xs + ys + 5'sd6);
      end
      MODE_DDR: begin
        kind = KIND_AVG3;
        base = 4'(xs - ys + 5'sd4);
      end
      MODE_VR: begin
        zv = (xs <<< 1) - ys;
        kv = xs - (ys >>> 1);
        if (!zv[4] && !zv[0]) begin
          kind = KIND_AVG2;
          base = 4'(kv + 5'sd5);
        end else if (!zv[4]) begin
          kind = KIND_AVG3;
          base = 4'(kv + 5'sd4);
        end else if (zv == -5'sd1) begin
          kind = KIND_AVG3;
          base = 4'd4;
        end else begin
          kind = KIND_AVG3;
          base = 4'(5'sd5 - ys);
        end
      end
      MODE_HD: begin
        zv = (ys <<< 1) - xs;
        kv = ys - (xs >>> 1);
        if (!zv[4] && !zv[0]) begin
          kind = KIND_AVG2;
          base = 4'(5'sd4 - kv);
        end else if (!zv[4]) begin
          kind = KIND_AVG3;
          base = 4'(5'sd4 - kv);
        end else if (zv == -5'sd1) begin
          kind = KIND_AVG3;
          base = 4'd4;
        end else begin
          kind = KIND_AVG3;
          base = 4'(xs + 5'sd3);
        end
      end
      MODE_VL: begin
        kv   = xs + (ys >>> 1);
        kind = ys[0] ? KIND_AVG3 : KIND_AVG2;
        base = 4'(kv + 5'sd6);
      end
      MODE_HU: begin
        zv = xs + (ys <<< 1);
        kv = ys + (xs >>> 1);
        if (zv > 5'sd5) begin
          kind = KIND_COPY;
          base = 4'd1;
        end else if (zv == 5'sd5) begin
          // left_3 doubled at the bottom edge
          kind = KIND_AVG3;
          base = 4'd0;
        end else if (!zv[0]) begin
          kind = KIND_AVG2;
          base = 4'(5'sd3 - kv);
        end else begin
          kind = KIND_AVG3;
          base = 4'(5'sd2 - kv);
        end
      end
      default: begin
        kind = KIND_FILL;
      end
    endcase
  end

  assign tap_a = nbr_i[base];
  assign tap_b = nbr_i[base + 4'd1];
  assign tap_c = nbr_i[base + 4'd2];

  assign sum2 = 10'(tap_a) + 10'(tap_b) + 10'd1;
  assign sum3 = 10'(tap_a) + {1'b0, tap_b, 1'b0} + 10'(tap_c) + 10'd2;

  always_comb begin
    case (kind)
      KIND_COPY: pel_o = tap_a;
      KIND_AVG2: pel_o = sum2[8:1];
      KIND_AVG3: pel_o = sum3[9:2];
      KIND_DC:   pel_o = dc_i;
      KIND_FILL: pel_o = FILL_PEL;
      default:   pel_o = FILL_PEL;
    endcase
  end

endmodule

>>> design/intra_4x4_predictor_top.sv
// Top level of the 4x4 intra predictor: item register, four pixel lanes and
// the output row register. Depends on ip4_pkg, ip4_chan_if, ip4_nbr_prep, ip4_lane.
//
// Usage:
//   blk_i carries one block request per transfer: the mode and the nine
//   neighbor samples (four above, four left, the corner). row_o returns the
//   predicted 4x4 block as four row transfers, top row first, each with its
//   row_index; last_row marks the fourth.
//   Order: the request is registered first, then the lanes' row 0 is registered in
//   the output row register; rows 1..3 follow one per cycle while row_o.ready stays high.
//   Throughput: set by the single output row register, which the four lanes fill
//   once per cycle while row_o.ready stays high. The next request is taken in
//   the cycle that row 3 enters the output register, so blocks stream with
//   no gap.
//   Stalls: when row_o.ready is low while a row is held, that row stays and the lanes
//   stop advancing; blk_i.ready stays low until the held block's last row moves.
//   Reset: rst_ni clears the busy flag, row counter and output valid; no
//   rows are pending afterward.
module intra_4x4_predictor_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ip4_in_if.sink    blk_i,
  ip4_out_if.source row_o
);
  import ip4_pkg::*;

  // held request
  logic       busy_q, busy_d;
  logic [1:0] row_q, row_d;
  logic [3:0] mode_q;
  pel_row_t   above_q;
  pel_row_t   left_q;
  pel_t       corner_q;

  // output row register
  logic       ovalid_q, ovalid_d;
  logic [1:0] orow_q;
  pel_row_t   opel_q;
  logic       olast_q;

  logic       take;
  logic       adv;
  logic       row_done;
  nbr_line_t  nbr;
  pel_t       dc_val;
  pel_row_t   lane_pel;

  // Advance a row whenever the output register is empty or being drained.
  assign adv      = busy_q && (!ovalid_q || row_o.ready);
  assign row_done = adv && (row_q == LAST_ROW);
  assign blk_i.ready = !busy_q || row_done;
  assign take     = blk_i.valid && blk_i.ready;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (take) begin
      busy_d = 1'b1;
      row_d  = '0;
    end else if (row_done) begin
      busy_d = 1'b0;
    end else if (adv) begin
      row_d  = row_q + 2'd1;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (adv) begin
      ovalid_d = 1'b1;
    end else if (row_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Capture the request payload on transfer.
  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q   <= blk_i.mode;
      above_q  <= {blk_i.above_3, blk_i.above_2, blk_i.above_1, blk_i.above_0};
      left_q   <= {blk_i.left_3, blk_i.left_2, blk_i.left_1, blk_i.left_0};
      corner_q <= blk_i.corner;
    end
  end

  ip4_nbr_prep u_prep (
    .above_i  (above_q),
    .left_i   (left_q),
    .corner_i (corner_q),
    .nbr_o    (nbr),
    .dc_o     (dc_val)
  );

  // One lane per column; all see the same row.
  for (genvar c = 0; c < 4; c++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.mode = mode_q;
    assign ctrl.row  = row_q;
    assign ctrl.col  = 2'(c);

    ip4_lane u_lane (
      .ctrl_i (ctrl),
      .nbr_i  (nbr),
      .dc_i   (dc_val),
      .pel_o  (lane_pel[c])
    );
  end

  // Merge the lane results into the output row.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      orow_q  <= row_q;
      opel_q  <= lane_pel;
      olast_q <= (row_q == LAST_ROW);
    end
  end

  assign row_o.valid     = ovalid_q;
  assign row_o.row_index = orow_q;
  assign row_o.pel_0     = opel_q[0];
  assign row_o.pel_1     = opel_q[1];
  assign row_o.pel_2     = opel_q[2];
  assign row_o.pel_3     = opel_q[3];
  assign row_o.last_row  = olast_q;

  // A taken request starts at row 0.
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (busy_q && row_q == 2'd0))
    else $error("request did not start at row 0");

  // A block is never dropped before its last row.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && row_q != LAST_ROW) |=> busy_q)
    else $error("block dropped mid-way");

  // Input only opens once the held block is finishing.
  a_ready_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_i.ready |-> (!busy_q || row_q == LAST_ROW))
    else $error("input ready while rows remain");

  // Each advance lands its row in the output register.
  a_adv_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (ovalid_q && orow_q == $past(row_q)))
    else $error("advanced row missing from output");

endmodule

>>> verif/ip4_row_checker.sv
`timescale 1ns / 1ps
// Row checker of the 4x4 intra predictor: watches both channels, predicts
// each block's four rows and compares them. Depends on ip4_pkg, ip4_chan_if.
module ip4_row_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ip4_in_if    blk_i,
  ip4_out_if   row_i,
  output int   mismatch_cnt_o,
  output int   rows_due_o
);
  import ip4_pkg::*;

  typedef struct {
    logic [1:0] row;
    pel_row_t   pels;
    logic       last;
  } pred_row_t;

  pred_row_t pending_rows[$];
  int        mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic pel_t avg2(input int a, input int b);
    return pel_t'((a + b + 1) >> 1);
  endfunction

  function automatic pel_t avg3(input int a, input int b, input int c);
    return pel_t'((a + 2 * b + c + 2) >> 2);
  endfunction

  // top[0] and lft[0] hold the corner; top[1..8] are above samples with the
  // above-right half replicated from above_3, lft[1..4] are left samples.
  function automatic pel_t predict_pel(input logic [3:0] mode, input int top[9],
                                       input int lft[5], input int x, input int y);
    int z;
    int k;
    case (mode)
      MODE_VERT: return pel_t'(top[x + 1]);
      MODE_HORZ: return pel_t'(lft[y + 1]);
      MODE_DC:
        return pel_t'((top[1] + top[2] + top[3] + top[4] +
                       lft[1] + lft[2] + lft[3] + lft[4] + 4) >> 3);
      MODE_DDL: begin
        if (x == 3 && y == 3) return avg3(top[7], top[8], top[8]);
        return avg3(top[x + y + 1], top[x + y + 2], top[x + y + 3]);
      end
      MODE_DDR: begin
        if (x > y) return avg3(top[x - y - 1], top[x - y], top[x - y + 1]);
        if (x < y) return avg3(lft[y - x - 1], lft[y - x], lft[y - x + 1]);
        return avg3(top[1], top[0], lft[1]);
      end
      MODE_VR: begin
        z = 2 * x - y;
        k = x - (y >> 1);
        if (z >= 0 && z % 2 == 0) return avg2(top[k], top[k + 1]);
        if (z > 0) return avg3(top[k - 1], top[k], top[k + 1]);
        if (z == -1) return avg3(lft[1], top[0], top[1]);
        return avg3(lft[y], lft[y - 1], lft[y - 2]);
      end
      MODE_HD: begin
        z = 2 * y - x;
        k = y - (x >> 1);
        if (z >= 0 && z % 2 == 0) return avg2(lft[k], lft[k + 1]);
        if (z > 0) return avg3(lft[k - 1], lft[k], lft[k + 1]);
        if (z == -1) return avg3(lft[1], top[0], top[1]);
        return avg3(top[x], top[x - 1], top[x - 2]);
      end
      MODE_VL: begin
        k = x + (y >> 1);
        if (y % 2 == 0) return avg2(top[k + 1], top[k + 2]);
        return avg3(top[k + 1], top[k + 2], top[k + 3]);
      end
      MODE_HU: begin
        z = x + 2 * y;
        k = y + (x >> 1);
        if (z > 5) return pel_t'(lft[4]);
        if (z == 5) return avg3(lft[3], lft[4], lft[4]);
        if (z % 2 == 0) return avg2(lft[k + 1], lft[k + 2]);
        return avg3(lft[k + 1], lft[k + 2], lft[k + 3]);
      end
      default: return FILL_PEL;
    endcase
  endfunction

  task automatic predict_block_rows();
    int        top[9];
    int        lft[5];
    pred_row_t exp_row;
    top[0] = blk_i.corner;
    top[1] = blk_i.above_0;
    top[2] = blk_i.above_1;
    top[3] = blk_i.above_2;
    top[4] = blk_i.above_3;
    for (int i = 5; i < 9; i++) top[i] = top[4];
    lft[0] = blk_i.corner;
    lft[1] = blk_i.left_0;
    lft[2] = blk_i.left_1;
    lft[3] = blk_i.left_2;
    lft[4] = blk_i.left_3;
    for (int y = 0; y < 4; y++) begin
      exp_row.row = 2'(y);
      for (int x = 0; x < 4; x++) exp_row.pels[x] = predict_pel(blk_i.mode, top, lft, x, y);
      exp_row.last = (2'(y) == LAST_ROW);
      pending_rows.push_back(exp_row);
    end
  endtask

  task automatic check_row();
    pred_row_t exp_row;
    pel_t      got[4];
    if (pending_rows.size() == 0) begin
      report_mismatch("row with nothing pending, row_index", row_i.row_index, -1);
      return;
    end
    exp_row = pending_rows.pop_front();
    got[0] = row_i.pel_0;
    got[1] = row_i.pel_1;
    got[2] = row_i.pel_2;
    got[3] = row_i.pel_3;
    if (row_i.row_index !== exp_row.row)
      report_mismatch("row_index", row_i.row_index, exp_row.row);
    for (int x = 0; x < 4; x++)
      if (got[x] !== exp_row.pels[x])
        report_mismatch($sformatf("pel_%0d of row %0d", x, exp_row.row), got[x],
                        exp_row.pels[x]);
    if (row_i.last_row !== exp_row.last)
      report_mismatch($sformatf("last_row of row %0d", exp_row.row), row_i.last_row,
                      exp_row.last);
  endtask

  // Older rows leave before the new block's rows join the back of the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (row_i.valid && row_i.ready) check_row();
      if (blk_i.valid && blk_i.ready) predict_block_rows();
    end
    rows_due_o <= pending_rows.size();
  end

endmodule

>>> verif/intra_4x4_predictor_top_tb.sv
`timescale 1ns / 1ps
// Testbench top of the 4x4 intra predictor: clock, reset, block stimulus,
// row back-pressure and verdict. Depends on ip4_pkg, ip4_chan_if, ip4_row_checker.
module intra_4x4_predictor_top_tb;
  import ip4_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int RANDOM_ITEMS = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatch_cnt;
  int   rows_due;
  int   idle_cycles = 0;
  int   ready_hold = 0;
  bit   gaps_off = 1'b0;

  ip4_in_if  blk_if ();
  ip4_out_if row_if ();

  intra_4x4_predictor_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .blk_i  (blk_if),
    .row_o  (row_if)
  );

  ip4_row_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blk_i          (blk_if),
    .row_i          (row_if),
    .mismatch_cnt_o (mismatch_cnt),
    .rows_due_o     (rows_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Row back-pressure: mostly short runs of ready, short stalls, now and then a
  // long stall, and occasional long stretches with ready held high throughout.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          row_if.ready <= 1'b1;
          ready_hold   <= $urandom_range(0, 6);
        end
        5: begin
          row_if.ready <= 1'b1;
          ready_hold   <= $urandom_range(40, 80);
        end
        6, 7, 8: begin
          row_if.ready <= 1'b0;
          ready_hold   <= $urandom_range(0, 2);
        end
        default: begin
          row_if.ready <= 1'b0;
          ready_hold   <= $urandom_range(10, 30);
        end
      endcase
    end
  end

  // Watchdog: any transfer on either side restarts the idle count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((blk_if.valid && blk_if.ready) || (row_if.valid && row_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly back-to-back, a few short gaps and the odd long one; none while
  // gaps_off is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (gaps_off || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Lean on the extremes so saturated averages and rounding carries show up.
  function automatic pel_t pick_pel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return pel_t'($urandom_range(0, 255));
  endfunction

  // Hold valid low for the gap, present one block and wait for its transfer.
  // valid is lowered only when a gap follows, so it never toggles within a step.
  task automatic send_block(input logic [3:0] md, input pel_t abv[4], input pel_t lft[4],
                            input pel_t cor, input int gap);
    if (gap > 0) begin
      blk_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    blk_if.valid   <= 1'b1;
    blk_if.mode    <= md;
    blk_if.above_0 <= abv[0];
    blk_if.above_1 <= abv[1];
    blk_if.above_2 <= abv[2];
    blk_if.above_3 <= abv[3];
    blk_if.left_0  <= lft[0];
    blk_if.left_1  <= lft[1];
    blk_if.left_2  <= lft[2];
    blk_if.left_3  <= lft[3];
    blk_if.corner  <= cor;
    do @(posedge clk_i); while (!blk_if.ready);
  endtask

  task automatic send_random_block(input logic [3:0] md);
    pel_t abv[4];
    pel_t lft[4];
    for (int i = 0; i < 4; i++) begin
      abv[i] = pick_pel();
      lft[i] = pick_pel();
    end
    send_block(md, abv, lft, pick_pel(), pick_gap());
  endtask

  initial begin
    pel_t       zeros[4];
    pel_t       ones[4];
    pel_t       alt_a[4];
    pel_t       alt_b[4];
    logic [3:0] md;

    zeros = '{8'd0, 8'd0, 8'd0, 8'd0};
    ones  = '{8'd255, 8'd255, 8'd255, 8'd255};
    alt_a = '{8'd0, 8'd255, 8'd0, 8'd255};
    alt_b = '{8'd255, 8'd0, 8'd255, 8'd0};

    blk_if.valid   <= 1'b0;
    blk_if.mode    <= '0;
    blk_if.above_0 <= '0;
    blk_if.above_1 <= '0;
    blk_if.above_2 <= '0;
    blk_if.above_3 <= '0;
    blk_if.left_0  <= '0;
    blk_if.left_1  <= '0;
    blk_if.left_2  <= '0;
    blk_if.left_3  <= '0;
    blk_if.corner  <= '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sweep every mode code once, the fill codes above horizontal-up included.
    for (int m = 0; m < 16; m++) send_random_block(4'(m));

    // Extremes: flat black and flat white blocks, DC rounding at both ends,
    // and alternating samples that drive every tap of the directional filters.
    send_block(MODE_DC,  zeros, zeros, 8'd0,   pick_gap());
    send_block(MODE_DC,  ones,  ones,  8'd255, pick_gap());
    send_block(MODE_DDR, ones,  ones,  8'd255, pick_gap());
    send_block(MODE_VR,  ones,  ones,  8'd255, pick_gap());
    send_block(MODE_HU,  ones,  ones,  8'd255, pick_gap());
    send_block(MODE_DDL, alt_a, alt_b, 8'd255, pick_gap());
    send_block(MODE_HD,  alt_a, alt_b, 8'd0,   pick_gap());
    send_block(MODE_VL,  alt_b, alt_a, 8'd0,   pick_gap());

    // Random blocks, mostly directional modes; every other run of 20 goes
    // back-to-back so the row register refills with no gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) gaps_off = ((n / 20) % 2 == 1);
      if ($urandom_range(0, 99) < 80) md = 4'($urandom_range(0, 8));
      else md = 4'($urandom_range(9, 15));
      send_random_block(md);
    end
    blk_if.valid <= 1'b0;

    // Drain: step past the last transfer so the pending count includes its
    // rows, wait for every predicted row, then wait on to catch any stray
    // row after the last one.
    do @(posedge clk_i); while (rows_due != 0);
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
